FILE: hw/rtl/mtfa_pkg.sv
// shared types and constants for the mode filter block
`default_nettype none

package mtfa_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;

    // write port and both read addresses of the value store
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_store_req;

endpackage

`default_nettype wire

FILE: hw/rtl/mtfa_store.sv
// value store: one write port, two registered read ports
`default_nettype none

module mtfa_store
    import mtfa_pkg::*;
(
    input  wire        i_clk,
    input  t_store_req i_req,
    output t_data      o_rd_a,
    output t_data      o_rd_b
);

    t_data r_mem [STORE_DEPTH];
    t_data r_rd_a;
    t_data r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_a <= r_mem[i_req.raddr_a];
        r_rd_b <= r_mem[i_req.raddr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

FILE: hw/rtl/mode_then_filter_above_top.sv
// top level of the mode filter: load, mode search and filtered replay
`default_nettype none

// usage
//   input: a transfer happens on a clock edge with start high and busy low.
//   each transfer carries one Q16.16 sample; end_of_block marks the last one.
//   samples without the end mark leave busy low, so they
//   can be sent back to back. samples beyond STORE_DEPTH are dropped and the
//   block's results then carry overflowed.
//   on the end mark busy rises and the block searches for the mode: for every
//   stored value it scans the whole store through one equality comparator.
//   a replay pass then emits, in load order, each stored value not greater than
//   the mode; the last one has last_kept set. search and replay both run on the
//   dual read port store and the single shared compare path.
//   output: each result sits on the o_ ports for one cycle with o_strobe high;
//   the receiver cannot stall, so results must be taken as they come.
//   reset (synchronous, active low) empties the block and clears the mode;
//   store contents are not cleared and are never used before being written.

module mode_then_filter_above_top
    import mtfa_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          start,
    output logic         busy,
    input  wire  [31:0]  i_sample,
    input  wire          i_end_of_block,
    output logic         o_strobe,
    output logic [31:0]  o_kept_value,
    output logic         o_last_kept,
    output logic         o_overflowed
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;  // loading samples
    localparam logic [2:0] ST_SCAN   = 3'd1;  // issue store reads for one candidate
    localparam logic [2:0] ST_DRAIN  = 3'd2;  // last compare of the scan
    localparam logic [2:0] ST_UPDATE = 3'd3;  // fold candidate count into best
    localparam logic [2:0] ST_FILTER = 3'd4;  // replay reads in load order
    localparam logic [2:0] ST_FDRAIN = 3'd5;  // last replay compare
    localparam logic [2:0] ST_FLUSH  = 3'd6;  // emit held value as last

    logic [2:0] r_state, n_state;
    t_cnt       r_fill, n_fill;
    logic       r_ovf, n_ovf;
    t_addr      r_i, n_i;
    t_addr      r_j, n_j;
    t_cnt       r_cnt, n_cnt;
    t_cnt       r_best, n_best;
    t_data      r_mode, n_mode;
    logic       r_b_vld, n_b_vld;
    t_data      r_pend, n_pend;
    logic       r_have_pend, n_have_pend;
    logic       r_out_vld, n_out_vld;
    t_data      r_out_val, n_out_val;
    logic       r_out_last, n_out_last;
    logic       r_out_ovf, n_out_ovf;

    t_store_req w_req;
    t_data      w_rd_a;
    t_data      w_rd_b;
    logic       w_accept;
    logic       w_room;
    t_addr      w_last_idx;
    logic       w_hit;
    logic       w_keep;
    logic       w_better;

    assign w_accept   = start && (r_state == ST_IDLE);
    assign w_room     = (r_fill < CNT_W'(STORE_DEPTH));
    // index of the final stored value; the block holds at least one while busy
    assign w_last_idx = ADDR_W'(r_fill - 1'b1);

    assign w_req.we      = w_accept && w_room;
    assign w_req.waddr   = r_fill[ADDR_W-1:0];
    assign w_req.wdata   = t_data'(i_sample);
    assign w_req.raddr_a = r_i;
    assign w_req.raddr_b = r_j;

    mtfa_store u_store (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_rd_a (w_rd_a),
        .o_rd_b (w_rd_b)
    );

    // shared compare path: port a holds the candidate, port b the scanned value
    assign w_hit    = (w_rd_a == w_rd_b);
    assign w_keep   = (w_rd_b <= r_mode);
    // higher count wins, smaller value breaks a tie
    assign w_better = (r_cnt > r_best) || ((r_cnt == r_best) && (w_rd_a < r_mode));

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_cnt       = r_cnt;
        n_best      = r_best;
        n_mode      = r_mode;
        n_pend      = r_pend;
        n_have_pend = r_have_pend;
        n_out_vld   = 1'b0;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        // read data is valid in the cycle after a scan or replay address
        n_b_vld     = (r_state == ST_SCAN) || (r_state == ST_FILTER);

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_room) begin
                        n_fill = r_fill + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_end_of_block) begin
                        n_state = ST_SCAN;
                        n_i     = '0;
                        n_j     = '0;
                        n_cnt   = '0;
                        n_best  = '0;
                        n_mode  = '0;
                    end
                end
            end
            ST_SCAN, ST_DRAIN: begin
                if (r_b_vld && w_hit) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_state == ST_DRAIN) begin
                    n_state = ST_UPDATE;
                end else if (r_j == w_last_idx) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_UPDATE: begin
                if (w_better) begin
                    n_best = r_cnt;
                    n_mode = w_rd_a;
                end
                n_cnt = '0;
                n_j   = '0;
                if (r_i == w_last_idx) begin
                    n_state     = ST_FILTER;
                    n_have_pend = 1'b0;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_FILTER, ST_FDRAIN: begin
                // hold one kept value back so the final one can be marked last
                if (r_b_vld && w_keep) begin
                    if (r_have_pend) begin
                        n_out_vld  = 1'b1;
                        n_out_val  = r_pend;
                        n_out_last = 1'b0;
                        n_out_ovf  = r_ovf;
                    end
                    n_pend      = w_rd_b;
                    n_have_pend = 1'b1;
                end
                if (r_state == ST_FDRAIN) begin
                    n_state = ST_FLUSH;
                end else if (r_j == w_last_idx) begin
                    n_state = ST_FDRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_FLUSH: begin
                // the mode itself is always kept, so a value is held here
                n_out_vld  = 1'b1;
                n_out_val  = r_pend;
                n_out_last = 1'b1;
                n_out_ovf  = r_ovf;
                n_fill     = '0;
                n_ovf      = 1'b0;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_best      <= '0;
            r_mode      <= '0;
            r_b_vld     <= 1'b0;
            r_have_pend <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_best      <= n_best;
            r_mode      <= n_mode;
            r_b_vld     <= n_b_vld;
            r_have_pend <= n_have_pend;
            r_out_vld   <= n_out_vld;
        end
    end

    // counters and payload
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_cnt      <= n_cnt;
        r_pend     <= n_pend;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_strobe     = r_out_vld;
    assign o_kept_value = r_out_val;
    assign o_last_kept  = r_out_last;
    assign o_overflowed = r_out_ovf;

`ifndef ASSERT_OFF
    // results only come out of the replay or flush steps
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ($past(r_state) == ST_FILTER || $past(r_state) == ST_FDRAIN
                       || $past(r_state) == ST_FLUSH))
        else $error("result transfer outside the replay pass");

    // the last result leaves the block empty and ready to load
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_last) |-> (r_state == ST_IDLE && r_fill == '0 && !r_ovf))
        else $error("block not emptied after its last result");

    // fill count never passes the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    // an end-marked transfer starts the mode search
    a_end_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_end_of_block) |=> (r_state == ST_SCAN && r_fill != '0))
        else $error("end of block did not start the mode search");
`endif

endmodule

`default_nettype wire
